/* rtl/mlr_pkg.sv */
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared constants for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

    localparam int COORD_BITS_DEF = 10;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

endpackage

/* rtl/mlr_if.sv */
// ----------------------------------------------------------------------------
// mlr_cmd_if / mlr_pix_if
// Valid/ready channels carrying command beats and pixel beats.
// ----------------------------------------------------------------------------
interface mlr_cmd_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface mlr_pix_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

/* rtl/midpoint_line_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_unit
// Path: command beat -> input reg -> result reg -> pixel beat.
// Throughput: one command beat per cycle unless pixel_chan stalls. Each start,
// and each active-line step, emits one pixel via decision add and update.
// Reset: asynchronous, active low; no line active, all line state zero.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mlr_cmd_if.sink   cmd_chan,
    mlr_pix_if.source pixel_chan
);

    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 3;
    localparam int AW = COORD_BITS + 2;

    // input stage
    logic         in_valid_reg;
    logic         cmd_reg;
    logic [C-1:0] sx_reg, sy_reg, ex_reg, ey_reg;

    // line state
    logic [C-1:0]         cur_x_reg, cur_x_next;
    logic [C-1:0]         cur_y_reg, cur_y_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic [AW-1:0]        axial_incr_reg, axial_incr_next;
    logic signed [DW-1:0] diag_incr_reg, diag_incr_next;
    logic [C-1:0]         end_major_reg, end_major_next;
    logic                 steep_reg, steep_next;
    logic                 x_negative_reg, x_negative_next;
    logic                 y_negative_reg, y_negative_next;
    logic                 active_reg, active_next;

    // result stage
    logic         out_valid_reg, out_valid_next;
    logic [C-1:0] pix_x_reg, pix_x_next;
    logic [C-1:0] pix_y_reg, pix_y_next;
    logic         pix_last_reg, pix_last_next;

    logic go;
    logic emit;

    logic         xn, yn, st;
    logic [C-1:0] dx, dy, dmaj, dmin;
    logic [C-1:0] nx, ny;
    logic         dec_le_zero;

    assign go = in_valid_reg && (!out_valid_reg || pixel_chan.ready);
    assign cmd_chan.ready = !in_valid_reg || go;

    assign pixel_chan.valid   = out_valid_reg;
    assign pixel_chan.pixel_x = pix_x_reg;
    assign pixel_chan.pixel_y = pix_y_reg;
    assign pixel_chan.last    = pix_last_reg;

    always_comb
    begin
        xn   = ex_reg < sx_reg;
        yn   = ey_reg < sy_reg;
        dx   = xn ? (sx_reg - ex_reg) : (ex_reg - sx_reg);
        dy   = yn ? (sy_reg - ey_reg) : (ey_reg - sy_reg);
        st   = dy > dx;
        dmaj = st ? dy : dx;
        dmin = st ? dx : dy;

        dec_le_zero = decision_reg[DW-1] || (decision_reg == '0);

        nx = x_negative_reg ? (cur_x_reg - 1'b1) : (cur_x_reg + 1'b1);
        ny = y_negative_reg ? (cur_y_reg - 1'b1) : (cur_y_reg + 1'b1);

        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        decision_next   = decision_reg;
        axial_incr_next = axial_incr_reg;
        diag_incr_next  = diag_incr_reg;
        end_major_next  = end_major_reg;
        steep_next      = steep_reg;
        x_negative_next = x_negative_reg;
        y_negative_next = y_negative_reg;
        active_next     = active_reg;

        emit          = 1'b0;
        pix_x_next    = pix_x_reg;
        pix_y_next    = pix_y_reg;
        pix_last_next = pix_last_reg;

        if (go)
        begin
            unique case (cmd_reg)
                mlr_pkg::CMD_START:
                begin
                    x_negative_next = xn;
                    y_negative_next = yn;
                    steep_next      = st;
                    decision_next   = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
                    axial_incr_next = {1'b0, dmin, 1'b0};
                    diag_incr_next  = $signed({2'b00, dmin, 1'b0})
                                    - $signed({2'b00, dmaj, 1'b0});
                    end_major_next  = st ? ey_reg : ex_reg;
                    cur_x_next      = sx_reg;
                    cur_y_next      = sy_reg;
                    pix_last_next   = (sx_reg == ex_reg) && (sy_reg == ey_reg);
                    active_next     = !pix_last_next;
                    pix_x_next      = sx_reg;
                    pix_y_next      = sy_reg;
                    emit            = 1'b1;
                end
                mlr_pkg::CMD_STEP:
                begin
                    if (active_reg)
                    begin
                        if (dec_le_zero)
                        begin
                            decision_next = decision_reg + $signed({1'b0, axial_incr_reg});
                            if (steep_reg)
                                cur_y_next = ny;
                            else
                                cur_x_next = nx;
                        end
                        else
                        begin
                            decision_next = decision_reg + diag_incr_reg;
                            cur_x_next    = nx;
                            cur_y_next    = ny;
                        end
                        pix_last_next = (steep_reg ? cur_y_next : cur_x_next) == end_major_reg;
                        active_next   = !pix_last_next;
                        pix_x_next    = cur_x_next;
                        pix_y_next    = cur_y_next;
                        emit          = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (pixel_chan.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            decision_reg   <= '0;
            axial_incr_reg <= '0;
            diag_incr_reg  <= '0;
            end_major_reg  <= '0;
            steep_reg      <= 1'b0;
            x_negative_reg <= 1'b0;
            y_negative_reg <= 1'b0;
            active_reg     <= 1'b0;
        end
        else
        begin
            if (cmd_chan.ready)
                in_valid_reg <= cmd_chan.valid;
            out_valid_reg  <= out_valid_next;
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            decision_reg   <= decision_next;
            axial_incr_reg <= axial_incr_next;
            diag_incr_reg  <= diag_incr_next;
            end_major_reg  <= end_major_next;
            steep_reg      <= steep_next;
            x_negative_reg <= x_negative_next;
            y_negative_reg <= y_negative_next;
            active_reg     <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_chan.ready && cmd_chan.valid)
        begin
            cmd_reg <= cmd_chan.cmd;
            sx_reg  <= cmd_chan.start_x;
            sy_reg  <= cmd_chan.start_y;
            ex_reg  <= cmd_chan.end_x;
            ey_reg  <= cmd_chan.end_y;
        end
        pix_x_reg    <= pix_x_next;
        pix_y_reg    <= pix_y_next;
        pix_last_reg <= pix_last_next;
    end

endmodule
